>>> sv/fpas_pkg.sv
// package for the fp32 add/sub unit: constants and shared types
`timescale 1ns / 1ps
package fpas_pkg;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] QNAN_CANON = 32'h7FC0_0000;
  localparam logic [22:0] FRAC_MASK  = 23'h7F_FFFF;
  localparam logic [7:0]  EXP_MAX    = 8'hFF;
  localparam logic [31:0] INF_BITS   = 32'h7F80_0000;

  typedef struct packed {
    logic        special;   // result already fixed (nan, inf, zero)
    logic [31:0] special_bits;
    logic        sign;
    logic [8:0]  exp;
    logic [27:0] sum;       // aligned sum with guard, round, sticky
  } fpas_align_t;
endpackage

>>> sv/fpas_align.sv
// swap, alignment shift and mantissa add/subtract
`timescale 1ns / 1ps
module fpas_align
  import fpas_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output fpas_align_t res
);
  logic        sa, sb, swap, nan_a, nan_b, inf_a, inf_b;
  logic [7:0]  ea, eb, el, es;
  logic [23:0] ma, mb, ml, mss;
  logic        sl, ss;
  logic [7:0]  d;
  logic [26:0] xb, xbs, lostmask;
  logic [27:0] s;

  always_comb begin
    sa = a[31]; sb = b[31];
    nan_a = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    swap = (ea < eb) || ((ea == eb) && (ma < mb));
    el = swap ? eb : ea;  es = swap ? ea : eb;
    ml = swap ? mb : ma;  mss = swap ? ma : mb;
    sl = swap ? sb : sa;  ss = swap ? sa : sb;
    d  = el - es;
    xb = {mss, 3'b000};
    if (d >= 8'd27) begin
      xbs = {26'd0, (xb != 27'd0)};
    end else begin
      lostmask = ~(27'h7FF_FFFF << d[4:0]);
      xbs = (xb >> d[4:0]) | {26'd0, ((xb & lostmask) != 27'd0)};
    end
    lostmask = ~(27'h7FF_FFFF << d[4:0]);
    s = (sl == ss) ? ({1'b0, ml, 3'b000} + {1'b0, xbs})
                   : ({1'b0, ml, 3'b000} - {1'b0, xbs});
    res.sign = sl;
    res.exp  = {1'b0, el};
    res.sum  = s;
    res.special = 1'b1;
    res.special_bits = 32'd0;
    if (nan_a || nan_b) res.special_bits = QNAN_CANON;
    else if (inf_a && inf_b) res.special_bits = (sa != sb) ? QNAN_CANON : a;
    else if (inf_a) res.special_bits = a;
    else if (inf_b) res.special_bits = b;
    else if (s == 28'd0) res.special_bits = (sa & sb) ? SIGN_BIT : 32'd0;
    else res.special = 1'b0;
  end
endmodule

>>> sv/fpas_round.sv
// normalize, round to nearest even, flush and overflow
`timescale 1ns / 1ps
module fpas_round
  import fpas_pkg::*;
(
  input  fpas_align_t in_r,
  output logic [31:0] bits
);
  logic [27:0] s, sh;
  logic [8:0]  e;
  logic [4:0]  lz, lim, amt;
  logic [2:0]  low3;
  logic [24:0] m;
  logic        found;

  always_comb begin
    s = in_r.sum;
    e = in_r.exp;
    lz = 5'd0; found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && s[i]) begin
        found = 1'b1;
        lz = 5'(26 - i);
      end
    end
    lim = (e > 9'd27) ? 5'd26 : 5'(e - 9'd1);
    amt = (lz < lim) ? lz : lim;
    if (s[27]) begin
      sh = (s >> 1) | {27'd0, s[0]};
      e  = e + 9'd1;
    end else begin
      sh = s << amt;
      e  = e - {4'd0, amt};
    end
    low3 = sh[2:0];
    m = {1'b0, sh[26:3]};
    if (low3 > 3'd4 || (low3 == 3'd4 && m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      e = e + 9'd1;
    end
    if (in_r.special)              bits = in_r.special_bits;
    else if (e >= {1'b0, EXP_MAX}) bits = {in_r.sign, 31'd0} | INF_BITS;
    else if (!m[23])               bits = {in_r.sign, 31'd0};
    else                           bits = {in_r.sign, e[7:0], m[22:0] & FRAC_MASK};
  end
endmodule

>>> sv/fp32_add_sub_ftz_unit.sv
// top level of the binary32 add/subtract unit with flush to zero
`timescale 1ns / 1ps
// usage:
//  - drive in_req_type, in_operand_a, in_operand_b and pulse start; a request
//    is taken at each rising edge with start high (busy is always low)
//  - in_req_type 0 adds, 1 subtracts operand b from operand a
//  - align/add works on the input ports and feeds the pipeline register,
//    normalize/round feeds the result register
//  - throughput is one request per cycle, both stages take a new request
//    every cycle and nothing stalls
//  - out_valid strobes for one cycle with out_sum_bits; the receiver
//    cannot stall, so every result must be taken when shown
//  - nan inputs give 0x7FC00000, subnormal results flush to signed zero
//  - reset (rst_n low, synchronous) clears the valid pipeline only
module fp32_add_sub_ftz_unit
  import fpas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_sum_bits
);
  logic        v1_r, v2_r;
  fpas_align_t al, al_r;
  logic [31:0] rnd;

  assign busy = 1'b0;

  // stage 1: operand decode, swap, align, add
  fpas_align u_align (
    .a   (in_operand_a),
    .b   (in_operand_b ^ (in_req_type ? SIGN_BIT : 32'd0)),
    .res (al)
  );

  // stage 2: normalize and round
  fpas_round u_round (.in_r(al_r), .bits(rnd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    al_r         <= al;
    out_sum_bits <= rnd;
  end

  assign out_valid = v2_r;

  // every request yields exactly one result
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid) else $error("missing result");
  a_nores: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> ##1 !out_valid) else $error("spurious result");
  a_nbusy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

>>> verif/testbench.sv
// self-checking testbench for the binary32 add/subtract unit with flush to zero
`timescale 1ns / 1ps

class fp_sum_scoreboard;
  logic [31:0] pending_sums[$];
  int          mismatches;
  int          checked;

  // predicted sum for one request, flush-to-zero and canonical nan applied
  static function logic [31:0] predict_sum(logic sub, logic [31:0] a, logic [31:0] b_in);
    logic [31:0] b;
    logic        sa, sb, sgn, tb;
    logic [31:0] ea, eb, ma, mb, xa, xb, s, d, e, low3, t;
    logic        nan_a, nan_b, inf_a, inf_b;
    b = b_in ^ (sub ? fpas_pkg::SIGN_BIT : 32'h0);
    sa = a[31];
    sb = b[31];
    ea = {24'h0, a[30:23]};
    eb = {24'h0, b[30:23]};
    ma = {9'h0, a[22:0]};
    mb = {9'h0, b[22:0]};
    nan_a = (a[30:23] == fpas_pkg::EXP_MAX) && (a[22:0] != 0);
    nan_b = (b[30:23] == fpas_pkg::EXP_MAX) && (b[22:0] != 0);
    inf_a = (a[30:23] == fpas_pkg::EXP_MAX) && (a[22:0] == 0);
    inf_b = (b[30:23] == fpas_pkg::EXP_MAX) && (b[22:0] == 0);
    if (nan_a || nan_b) return fpas_pkg::QNAN_CANON;
    if (inf_a && inf_b) return (sa != sb) ? fpas_pkg::QNAN_CANON : a;
    if (inf_a) return a;
    if (inf_b) return b;
    if (ea == 0) ea = 1; else ma |= 32'h0080_0000;
    if (eb == 0) eb = 1; else mb |= 32'h0080_0000;
    // larger magnitude goes first
    if (ea < eb || (ea == eb && ma < mb)) begin
      t = ea; ea = eb; eb = t;
      t = ma; ma = mb; mb = t;
      tb = sa; sa = sb; sb = tb;
    end
    d = ea - eb;
    xa = ma << 3;
    xb = mb << 3;
    if (d >= 27) xb = (xb != 0) ? 1 : 0;
    else if (d > 0) xb = (xb >> d) | (((xb & ((32'h1 << d) - 1)) != 0) ? 1 : 0);
    s = (sa == sb) ? xa + xb : xa - xb;
    if (s == 0) return (sa & sb) ? fpas_pkg::SIGN_BIT : 32'h0;
    sgn = sa;
    e = ea;
    if (s >= (32'h1 << 27)) begin
      s = (s >> 1) | (s & 1);
      e++;
    end else begin
      while (s < (32'h1 << 26) && e > 1) begin
        s = s << 1;
        e--;
      end
    end
    low3 = s & 7;
    s = s >> 3;
    if (low3 > 4 || (low3 == 4 && s[0])) s++;
    if (s >= (32'h1 << 24)) begin
      s = s >> 1;
      e++;
    end
    if (e >= 255) return {sgn, 31'h0} | fpas_pkg::INF_BITS;
    if (!s[23]) return {sgn, 31'h0};
    return {sgn, e[7:0], s[22:0]};
  endfunction

  function void note_request(logic sub, logic [31:0] a, logic [31:0] b);
    pending_sums.push_back(predict_sum(sub, a, b));
  endfunction

  function void check_sum(logic [31:0] got);
    logic [31:0] want;
    checked++;
    if (pending_sums.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = pending_sums.pop_front();
    if (got !== want)
      report_mismatch($sformatf("sum_bits got %h want %h", got, want));
  endfunction

  function void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 30) $display("mismatch @%0t: %s", $time, msg);
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic        out_valid;
  logic [31:0] out_sum_bits;

  fp_sum_scoreboard sums;
  int               sent;
  bit               idle_on;

  fp32_add_sub_ftz_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .out_valid(out_valid), .out_sum_bits(out_sum_bits)
  );

  // 2 ns clock
  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // sample results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid) sums.check_sum(out_sum_bits);
  end

  // pick a random binary32 pattern biased toward the interesting classes
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hFF;                       // inf or nan
      1: v[30:23] = 8'h00;                       // zero or subnormal
      2: v[30:0] = {8'hFF, 23'h0};               // infinity
      3: v[30:0] = 31'h0;                        // signed zero
      4: v[30:23] = 8'($urandom_range(0, 3));    // near the flush boundary
      5: v[30:23] = 8'($urandom_range(250, 254)); // near overflow
      default: ;
    endcase
    return v;
  endfunction

  // one request: start raised at the falling edge, taken at the next rising edge;
  // start stays high so the next request can follow at once
  task automatic send_request(logic sub, logic [31:0] a, logic [31:0] b);
    in_req_type  <= sub;
    in_operand_a <= a;
    in_operand_b <= b;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sums.note_request(sub, a, b);
    sent++;
    @(negedge clk);
  endtask

  // random sender gap: with idling on, start is dropped low one time in six
  task automatic maybe_idle();
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // near-cancelling pair: b close to a, so subtraction normalizes far
  task automatic send_close_pair();
    logic [31:0] a, b;
    a = pick_operand();
    b = a ^ ($urandom() & 32'h0000_00FF);
    if ($urandom_range(0, 1)) b[23] = ~b[23];
    send_request(1'($urandom_range(0, 1)), a, b);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sums.pending_sums.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    sums = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = 1'b0;
    in_operand_a = 32'h0;
    in_operand_b = 32'h0;
    idle_on = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, both operations, each special case
    send_request(1'b0, 32'h3F80_0000, 32'h3F80_0000);   // 1 + 1
    send_request(1'b1, 32'h3F80_0000, 32'h3F80_0000);   // exact zero, +0
    send_request(1'b0, 32'h8000_0000, 32'h8000_0000);   // -0 + -0 gives -0
    send_request(1'b1, 32'h8000_0000, 32'h0000_0000);   // -0 - +0 gives -0
    send_request(1'b0, 32'h7FC0_0001, 32'h3F80_0000);   // quiet nan
    send_request(1'b1, 32'h3F80_0000, 32'h7F80_0001);   // signalling nan
    send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // all ones
    send_request(1'b1, 32'h7F80_0000, 32'h7F80_0000);   // inf - inf invalid
    send_request(1'b0, 32'h7F80_0000, 32'hFF80_0000);   // inf + -inf invalid
    send_request(1'b0, 32'h7F80_0000, 32'h7F80_0000);   // inf + inf
    send_request(1'b1, 32'h3F80_0000, 32'h7F80_0000);   // one infinite, negated
    send_request(1'b0, 32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow
    send_request(1'b1, 32'hFF7F_FFFF, 32'h7F7F_FFFF);   // negative overflow
    send_request(1'b0, 32'h0000_0001, 32'h0000_0001);   // subnormal result flushed
    send_request(1'b1, 32'h8080_0000, 32'h8000_0001);   // flushes to -0
    send_request(1'b0, 32'h007F_FFFF, 32'h0000_0001);   // sums exactly to smallest normal
    send_request(1'b0, 32'h0040_0000, 32'h0040_0000);   // subnormals sum to normal
    send_request(1'b0, 32'h4B80_0000, 32'h3F80_0000);   // tie, round to even
    send_request(1'b0, 32'h3F80_0000, 32'h0000_0001);   // far alignment sticky
    send_request(1'b1, 32'h3F80_0001, 32'h3F80_0000);   // deep cancellation
    send_request(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);   // zero and nan
    send_request(1'b0, 32'h0000_0000, 32'h0000_0000);   // all zeros
    drain();

    // random with idling
    idle_on = 1'b1;
    repeat (700) begin
      maybe_idle();
      if ($urandom_range(0, 3) == 0) send_close_pair();
      else send_request(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
      if (sent == 300) drain();   // sender holds off until all results are in
    end

    // last part back to back, no idling
    idle_on = 1'b0;
    repeat (100) begin
      if ($urandom_range(0, 3) == 0) send_close_pair();
      else send_request(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
    end
    drain();

    $display("run covered %0d add/sub requests (%0d results checked)", sent, sums.checked);
    $display("directed nan, infinity, signed zero, overflow and flush cases plus random");
    if (sums.mismatches == 0 && sums.pending_sums.size() == 0) begin
      $display("** fp32_add_sub_ftz_unit: PASSED **");
    end else begin
      $display("** fp32_add_sub_ftz_unit: FAILED **");
    end
    $finish;
  end

  // generous fixed limit on run time
  initial begin
    #200000;
    $display("timeout");
    $display("** fp32_add_sub_ftz_unit: FAILED **");
    $finish;
  end
endmodule
